>>> rtl/core/raster_timing_generator_core_defines.svh
// Assertion macros shared by the raster timing generator RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef RASTER_TIMING_GENERATOR_CORE_DEFINES_SVH
`define RASTER_TIMING_GENERATOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rtg_pkg.sv
// Types and constants for the raster timing generator.
// Used by rtg_step and raster_timing_generator_core; no dependencies.
`default_nettype none

package rtg_pkg;

  localparam int unsigned CoordW = 10;
  localparam int unsigned ColourW = 4;
  localparam int unsigned FrameW = 6;
  localparam int unsigned IntCntW = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CoordW-1:0] BORDER_STEP_MASK = 10'd1;
  localparam logic [CoordW-1:0] INT_X = 10'd0;
  localparam logic [CoordW-1:0] INT_Y = 10'd0;
  localparam logic [IntCntW-1:0] INT_LEN = 8'd64;
  // Frame counter bit that drives the attribute flash phase.
  localparam int unsigned FLASH_BIT = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LINE_LENGTH     = 3'd0,
    REG_FRAME_LINES     = 3'd1,
    REG_HBLANK_POSITION = 3'd2,
    REG_VBLANK_POSITION = 3'd3,
    REG_BORDER_LEFT     = 3'd4,
    REG_BORDER_TOP      = 3'd5,
    REG_SCREEN_WIDTH    = 3'd6,
    REG_SCREEN_HEIGHT   = 3'd7
  } rtg_reg_t;

  typedef struct packed {
    logic [CoordW-1:0] line_length;
    logic [CoordW-1:0] frame_lines;
    logic [CoordW-1:0] hblank_position;
    logic [CoordW-1:0] vblank_position;
    logic [CoordW-1:0] border_left;
    logic [CoordW-1:0] border_top;
    logic [CoordW-1:0] screen_width;
    logic [CoordW-1:0] screen_height;
  } rtg_cfg_t;

  localparam rtg_cfg_t CFG_RESET = '{
    line_length:     10'd448,
    frame_lines:     10'd320,
    hblank_position: 10'd384,
    vblank_position: 10'd288,
    border_left:     10'd74,
    border_top:      10'd48,
    screen_width:    10'd256,
    screen_height:   10'd192
  };

  typedef struct packed {
    logic [CoordW-1:0]  raster_x;
    logic [CoordW-1:0]  raster_y;
    logic [CoordW-1:0]  dots_since_hblank;
    logic [CoordW-1:0]  lines_since_vblank;
    logic               hblank_flag;
    logic               vblank_flag;
    logic               hborder_flag;
    logic               vborder_flag;
    logic [ColourW-1:0] border_latch;
    logic [FrameW-1:0]  frame_counter;
    logic [IntCntW-1:0] interrupt_counter;
  } rtg_state_t;

  // Packed so that dot_x sits in the lowest bits of the result tdata.
  typedef struct packed {
    logic               vblank_strobe;
    logic               hblank_strobe;
    logic               flash_phase;
    logic               frame_interrupt;
    logic               in_vborder;
    logic               in_hborder;
    logic               in_vblank;
    logic               in_hblank;
    logic [ColourW-1:0] border_colour;
    logic [CoordW-1:0]  line_y;
    logic [CoordW-1:0]  dot_x;
  } rtg_result_t;

endpackage

`default_nettype wire

>>> rtl/core/raster_timing_generator_core.sv
// Raster timing generator: one result per dot clock tick, with config registers.
// Depends on rtg_pkg, rtg_step and raster_timing_generator_core_defines.svh.
//
// Usage:
//   Each transfer on the in_ channel is one dot clock tick; in_tdata[3:0]
//   carries the border colour most recently written by the processor.
//   Every tick produces exactly one transfer on the out_ channel with the
//   raster position after the tick, the latched border colour, the blanking
//   and border flags, the interrupt level, the flash phase and the two
//   blanking strobes.
//   A tick accepted at a clock edge is presented on out_ from the next cycle.
//   Throughput is one tick per cycle while out_tready is high, set by the
//   single result register, which reloads in the same cycle it is emptied.
//   When the receiver stalls, the result is held and in_tready drops until
//   the result is taken; no tick is lost or repeated.
//   Reset (synchronous, rst_n low) clears all raster state, empties the
//   result register and loads the default timing registers. The cfg_ port
//   writes register cfg_index with cfg_wdata at any edge with cfg_we high;
//   write only while no tick is in flight.
`default_nettype none

module raster_timing_generator_core (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_tvalid,
  output logic                          in_tready,
  input  wire [7:0]                     in_tdata,   // [3:0] border_next, [7:4] zero
  output logic                          out_tvalid,
  input  wire                           out_tready,
  // [9:0] dot_x, [19:10] line_y, [23:20] border_colour, [24] in_hblank,
  // [25] in_vblank, [26] in_hborder, [27] in_vborder, [28] frame_interrupt,
  // [29] flash_phase, [30] hblank_strobe, [31] vblank_strobe
  output logic [31:0]                   out_tdata,
  input  wire                           cfg_we,
  input  wire [rtg_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire [rtg_pkg::CoordW-1:0]     cfg_wdata
);
  import rtg_pkg::*;
  `include "raster_timing_generator_core_defines.svh"

  rtg_cfg_t    cfg_r;
  rtg_cfg_t    cfg_nxt;
  rtg_state_t  state_r;
  rtg_state_t  state_nxt;
  rtg_result_t result_r;
  rtg_result_t result_nxt;
  logic        out_valid_r;
  logic        in_xfer;
  logic        res_hstrobe;
  logic        res_vstrobe;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  rtg_step u_step (
    .cfg_i         (cfg_r),
    .state_i       (state_r),
    .border_next_i (in_tdata[ColourW-1:0]),
    .state_o       (state_nxt),
    .result_o      (result_nxt)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (rtg_reg_t'(cfg_index))
        REG_LINE_LENGTH:     cfg_nxt.line_length     = cfg_wdata;
        REG_FRAME_LINES:     cfg_nxt.frame_lines     = cfg_wdata;
        REG_HBLANK_POSITION: cfg_nxt.hblank_position = cfg_wdata;
        REG_VBLANK_POSITION: cfg_nxt.vblank_position = cfg_wdata;
        REG_BORDER_LEFT:     cfg_nxt.border_left     = cfg_wdata;
        REG_BORDER_TOP:      cfg_nxt.border_top      = cfg_wdata;
        REG_SCREEN_WIDTH:    cfg_nxt.screen_width    = cfg_wdata;
        REG_SCREEN_HEIGHT:   cfg_nxt.screen_height   = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      if (in_xfer) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = result_r;

  assign res_hstrobe = out_valid_r && result_r.hblank_strobe;
  assign res_vstrobe = out_valid_r && result_r.vblank_strobe;

  `RTG_ASSERT_NEXT(a_xfer_fills_result, in_xfer, out_valid_r, "accepted tick gave no result")
  `RTG_ASSERT_SAME(a_empty_means_ready, !out_valid_r, in_tready, "input stalled while empty")
  `RTG_ASSERT_SAME(a_hstrobe_hblank, res_hstrobe, result_r.in_hblank, "hstrobe without hblank")
  `RTG_ASSERT_SAME(a_vstrobe_line, res_vstrobe, result_r.hblank_strobe, "vstrobe without hstrobe")
  `RTG_ASSERT_SAME(a_vstrobe_vblank, res_vstrobe, result_r.in_vblank, "vstrobe without vblank")

endmodule

`default_nettype wire

>>> rtl/core/rtg_step.sv
// Next-state and result logic for one dot clock tick of the raster generator.
// Purely combinational; depends on rtg_pkg.
`default_nettype none

module rtg_step (
  input  wire rtg_pkg::rtg_cfg_t         cfg_i,
  input  wire rtg_pkg::rtg_state_t       state_i,
  input  wire [rtg_pkg::ColourW-1:0]     border_next_i,
  output rtg_pkg::rtg_state_t            state_o,
  output rtg_pkg::rtg_result_t           result_o
);
  import rtg_pkg::*;

  logic [CoordW:0]   hend;
  logic [CoordW:0]   vend;
  logic [CoordW:0]   nx;
  logic [CoordW:0]   ny;
  logic              hstrobe;
  logic              vstrobe;
  rtg_state_t        s;

  // Border end positions keep their carry so that a sum past the counter
  // range never matches.
  assign hend = {1'b0, cfg_i.border_left} + {1'b0, cfg_i.screen_width};
  assign vend = {1'b0, cfg_i.border_top} + {1'b0, cfg_i.screen_height};

  always_comb begin
    s       = state_i;
    hstrobe = 1'b0;
    vstrobe = 1'b0;
    ny      = '0;

    if ((state_i.raster_x & BORDER_STEP_MASK) == '0) begin
      s.border_latch = border_next_i;
    end

    nx = {1'b0, state_i.raster_x} + 11'd1;
    s.dots_since_hblank = state_i.dots_since_hblank + 10'd1;
    if (nx >= {1'b0, cfg_i.line_length}) begin
      s.hblank_flag = 1'b0;
      nx = '0;
    end
    s.raster_x = nx[CoordW-1:0];

    if (s.raster_x == cfg_i.hblank_position) begin
      s.hblank_flag        = 1'b1;
      hstrobe              = 1'b1;
      s.dots_since_hblank  = '0;
      s.lines_since_vblank = state_i.lines_since_vblank + 10'd1;
      ny = {1'b0, state_i.raster_y} + 11'd1;
      if (ny >= {1'b0, cfg_i.frame_lines}) begin
        s.vblank_flag = 1'b0;
        ny = '0;
      end
      s.raster_y = ny[CoordW-1:0];
      if (s.raster_y == cfg_i.vblank_position) begin
        s.vblank_flag        = 1'b1;
        vstrobe              = 1'b1;
        s.lines_since_vblank = '0;
        s.frame_counter      = state_i.frame_counter + 6'd1;
      end
      // The start test comes last so that it wins when start equals end.
      if ({1'b0, s.raster_y} == vend) begin
        s.vborder_flag = 1'b1;
      end
      if (s.raster_y == cfg_i.border_top) begin
        s.vborder_flag = 1'b0;
      end
    end

    if ({1'b0, s.raster_x} == hend) begin
      s.hborder_flag = 1'b1;
    end else if (s.raster_x == cfg_i.border_left) begin
      s.hborder_flag = 1'b0;
    end

    if (state_i.interrupt_counter != '0) begin
      s.interrupt_counter = state_i.interrupt_counter - 8'd1;
    end
    if (s.lines_since_vblank == INT_Y && s.dots_since_hblank == INT_X) begin
      s.interrupt_counter = INT_LEN;
    end
  end

  assign state_o = s;

  always_comb begin
    result_o.dot_x           = s.raster_x;
    result_o.line_y          = s.raster_y;
    result_o.border_colour   = s.border_latch;
    result_o.in_hblank       = s.hblank_flag;
    result_o.in_vblank       = s.vblank_flag;
    result_o.in_hborder      = s.hborder_flag;
    result_o.in_vborder      = s.vborder_flag;
    result_o.frame_interrupt = (s.interrupt_counter != '0);
    result_o.flash_phase     = s.frame_counter[FLASH_BIT];
    result_o.hblank_strobe   = hstrobe;
    result_o.vblank_strobe   = vstrobe;
  end

endmodule

`default_nettype wire

>>> test/raster_timing_checker.sv
// Checker for the raster timing generator: watches the tick, result and register
// channels, keeps its own model of the raster and compares every result transfer.
// Depends on rtg_pkg for the register codes, the timing defaults and the result layout.
module raster_timing_checker
  import rtg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [31:0]         out_tdata,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CoordW-1:0]   cfg_wdata,
  output int unsigned         mismatch_count,
  output int unsigned         results_owed
);

  rtg_cfg_t           timing;
  logic [CoordW-1:0]  pos_x, pos_y, dot_cnt, line_cnt;
  logic               hblank, vblank, hborder, vborder;
  logic [ColourW-1:0] colour_latch;
  logic [FrameW-1:0]  frame_cnt;
  logic [IntCntW-1:0] irq_cnt;

  rtg_result_t        predicted_raster[$];
  int unsigned        result_index;

  initial begin
    mismatch_count = 0;
    results_owed = 0;
    result_index = 0;
  end

  // Advances the model by one dot and returns what the block should show for it.
  task automatic advance_raster(input logic [ColourW-1:0] colour_in, output rtg_result_t res);
    logic [CoordW:0]    nx, ny, hend, vend;
    logic               hs, vs;
    logic [ColourW-1:0] shown;
    hs = 1'b0;
    vs = 1'b0;
    // The border ends are formed one bit wider so that a sum past the top is never hit.
    hend = {1'b0, timing.border_left} + {1'b0, timing.screen_width};
    vend = {1'b0, timing.border_top} + {1'b0, timing.screen_height};

    if ((pos_x & BORDER_STEP_MASK) == '0) colour_latch = colour_in;
    shown = colour_latch;

    nx = {1'b0, pos_x} + 1'b1;
    dot_cnt = dot_cnt + 1'b1;
    if (nx >= {1'b0, timing.line_length}) begin
      hblank = 1'b0;
      nx = '0;
    end
    pos_x = nx[CoordW-1:0];

    if (pos_x == timing.hblank_position) begin
      hblank = 1'b1;
      hs = 1'b1;
      dot_cnt = '0;
      line_cnt = line_cnt + 1'b1;
      ny = {1'b0, pos_y} + 1'b1;
      if (ny >= {1'b0, timing.frame_lines}) begin
        vblank = 1'b0;
        ny = '0;
      end
      pos_y = ny[CoordW-1:0];
      if (pos_y == timing.vblank_position) begin
        vblank = 1'b1;
        vs = 1'b1;
        line_cnt = '0;
        frame_cnt = frame_cnt + 1'b1;
      end
      // When start and end coincide vertically, the start test has the last word.
      if ({1'b0, pos_y} == vend) vborder = 1'b1;
      if (pos_y == timing.border_top) vborder = 1'b0;
    end

    // Horizontally it is the other way round: the end test wins.
    if ({1'b0, pos_x} == hend) hborder = 1'b1;
    else if (pos_x == timing.border_left) hborder = 1'b0;

    if (irq_cnt != '0) irq_cnt = irq_cnt - 1'b1;
    if (line_cnt == INT_Y && dot_cnt == INT_X) irq_cnt = INT_LEN;

    res.dot_x = pos_x;
    res.line_y = pos_y;
    res.border_colour = shown;
    res.in_hblank = hblank;
    res.in_vblank = vblank;
    res.in_hborder = hborder;
    res.in_vborder = vborder;
    res.frame_interrupt = (irq_cnt != '0);
    res.flash_phase = frame_cnt[FLASH_BIT];
    res.hblank_strobe = hs;
    res.vblank_strobe = vs;
  endtask

  task automatic compare_field(input string field, input int unsigned want_v,
                               input int unsigned got_v, inout bit differs);
    if (want_v != got_v) begin
      if (mismatch_count < 10) begin
        $display("result %0d %s: expected %0d, got %0d", result_index, field, want_v, got_v);
      end
      differs = 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    rtg_result_t want, got;
    bit differs;
    if (!rst_n) begin
      timing = CFG_RESET;
      pos_x = '0;
      pos_y = '0;
      dot_cnt = '0;
      line_cnt = '0;
      hblank = 1'b0;
      vblank = 1'b0;
      hborder = 1'b0;
      vborder = 1'b0;
      colour_latch = '0;
      frame_cnt = '0;
      irq_cnt = '0;
      predicted_raster.delete();
    end else begin
      if (cfg_we) begin
        case (rtg_reg_t'(cfg_index))
          REG_LINE_LENGTH:     timing.line_length = cfg_wdata;
          REG_FRAME_LINES:     timing.frame_lines = cfg_wdata;
          REG_HBLANK_POSITION: timing.hblank_position = cfg_wdata;
          REG_VBLANK_POSITION: timing.vblank_position = cfg_wdata;
          REG_BORDER_LEFT:     timing.border_left = cfg_wdata;
          REG_BORDER_TOP:      timing.border_top = cfg_wdata;
          REG_SCREEN_WIDTH:    timing.screen_width = cfg_wdata;
          REG_SCREEN_HEIGHT:   timing.screen_height = cfg_wdata;
          default: ;
        endcase
      end

      // The result side is handled first so that a tick taken at this edge is
      // never matched against a result leaving at the same edge.
      if (out_tvalid && out_tready) begin
        got = rtg_result_t'(out_tdata);
        if (predicted_raster.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("result %0d arrived with nothing predicted: %h", result_index, out_tdata);
          end
          mismatch_count++;
        end else begin
          want = predicted_raster.pop_front();
          differs = 1'b0;
          compare_field("dot_x", want.dot_x, got.dot_x, differs);
          compare_field("line_y", want.line_y, got.line_y, differs);
          compare_field("border_colour", want.border_colour, got.border_colour, differs);
          compare_field("in_hblank", want.in_hblank, got.in_hblank, differs);
          compare_field("in_vblank", want.in_vblank, got.in_vblank, differs);
          compare_field("in_hborder", want.in_hborder, got.in_hborder, differs);
          compare_field("in_vborder", want.in_vborder, got.in_vborder, differs);
          compare_field("frame_interrupt", want.frame_interrupt, got.frame_interrupt, differs);
          compare_field("flash_phase", want.flash_phase, got.flash_phase, differs);
          compare_field("hblank_strobe", want.hblank_strobe, got.hblank_strobe, differs);
          compare_field("vblank_strobe", want.vblank_strobe, got.vblank_strobe, differs);
          if (differs) mismatch_count++;
        end
        result_index++;
      end

      if (in_tvalid && in_tready) begin
        advance_raster(in_tdata[ColourW-1:0], want);
        predicted_raster.push_back(want);
      end
    end
    results_owed = predicted_raster.size();
  end

endmodule

>>> test/tb.sv
// Top of the raster timing generator testbench: clock, reset, tick stimulus,
// register programming and the verdict. Depends on rtg_pkg, the block and
// raster_timing_checker.
module tb;
  import rtg_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [31:0]         out_tdata;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CoordW-1:0]   cfg_wdata;
  int unsigned         mismatch_count;
  int unsigned         results_owed;

  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;

  raster_timing_generator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  raster_timing_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // The receiver decides afresh at every falling edge whether to take a result.
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One dot tick; returns just after the rising edge that took the transfer.
  task automatic send_tick(input logic [ColourW-1:0] colour);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {4'b0, colour};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input rtg_reg_t idx, input logic [CoordW-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_timing(input rtg_cfg_t t);
    write_reg(REG_LINE_LENGTH, t.line_length);
    write_reg(REG_FRAME_LINES, t.frame_lines);
    write_reg(REG_HBLANK_POSITION, t.hblank_position);
    write_reg(REG_VBLANK_POSITION, t.vblank_position);
    write_reg(REG_BORDER_LEFT, t.border_left);
    write_reg(REG_BORDER_TOP, t.border_top);
    write_reg(REG_SCREEN_WIDTH, t.screen_width);
    write_reg(REG_SCREEN_HEIGHT, t.screen_height);
  endtask

  initial begin
    rtg_cfg_t plan;
    int unsigned len;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_LINE_LENGTH;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Default timing: colour extremes on both phases of the latch step.
    send_tick(4'h0);
    send_tick(4'hF);
    send_tick(4'hF);
    send_tick(4'h0);
    send_tick(4'h5);
    send_tick(4'hA);
    for (int i = 0; i < 14; i++) send_tick(4'($urandom_range(15)));

    for (int phase = 0; phase < 16; phase++) begin
      wait_results_drained();
      case (phase)
        // Zero lengths, with border start and end equal on both axes.
        0: plan = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0};
        // Everything at the top; both border ends fall out of reach.
        1: plan = '{10'd1023, 10'd1023, 10'd1023, 10'd1023,
                    10'd1023, 10'd1023, 10'd1023, 10'd1023};
        // One dot per line and one line per frame: a new frame on every tick.
        2: plan = '{10'd1, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023};
        3: plan = '{10'd2, 10'd40, 10'd1, 10'd20, 10'd1, 10'd5, 10'd0, 10'd10};
        // The next two shrink the frame and then the line below the current position.
        4: plan = '{10'd40, 10'd3, 10'd0, 10'd2, 10'd7, 10'd1, 10'd20, 10'd1};
        5: plan = '{10'd3, 10'd5, 10'd2, 10'd4, 10'd1, 10'd2, 10'd1, 10'd1};
        default: begin
          if ($urandom_range(3) == 0) begin
            plan = rtg_cfg_t'(80'({$urandom, $urandom, $urandom}));
          end else begin
            plan.line_length = CoordW'($urandom_range(24, 1));
            plan.frame_lines = CoordW'($urandom_range(12, 1));
            plan.hblank_position = CoordW'($urandom_range(plan.line_length + 1));
            plan.vblank_position = CoordW'($urandom_range(plan.frame_lines + 1));
            plan.border_left = CoordW'($urandom_range(plan.line_length));
            plan.border_top = CoordW'($urandom_range(plan.frame_lines));
            plan.screen_width = CoordW'($urandom_range(plan.line_length));
            plan.screen_height = CoordW'($urandom_range(plan.frame_lines));
          end
        end
      endcase
      load_timing(plan);

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      len = (phase < 6) ? 40 : $urandom_range(80, 50);
      for (int i = 0; i < len; i++) send_tick(4'($urandom_range(15)));
    end

    wait_results_drained();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/rtg_pkg.sv
rtl/core/rtg_step.sv
rtl/core/raster_timing_generator_core.sv
test/raster_timing_checker.sv
test/tb.sv
